// File: rtl/tss_pkg.sv
// Shared types and constants for the text shadow syntax checker.
package tss_pkg;

  localparam int unsigned StateW = 5;

  typedef logic [StateW-1:0] pstate_t;

  localparam pstate_t StStart = 5'd0;
  localparam pstate_t StEnd   = 5'd17;

  typedef enum logic [1:0] {
    STATUS_PENDING  = 2'd0,
    STATUS_ACCEPTED = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CC_DIGIT,
    CC_HEX,
    CC_MINUS,
    CC_SPACE,
    CC_P,
    CC_X,
    CC_HASH,
    CC_COMMA,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic    ok;
    pstate_t nxt;
  } step_t;

endpackage

// File: rtl/text_shadow_syntax_checker.sv
// Shadow list syntax checker: one character word in, one status word per unstalled cycle.
// Takes one character word per cycle while char_stall is low and returns one status
// word for each. The word passes an input register, then the automaton step (class
// decode plus table lookup) updates the parse state and loads the result register in
// the same cycle, so a new word can enter every cycle unless the result side stalls.
// status is pending while a string is open and still valid, rejected from the first bad
// character on, and accepted or rejected with string_done set on the last word.
// An empty_string word closes the string at once with status accepted.
module text_shadow_syntax_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  input  logic       empty_string,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic       string_done
);
  import tss_pkg::*;

  logic       a_valid;
  logic [7:0] a_char;
  logic       a_last;
  logic       a_empty;

  pstate_t parse_state, parse_state_next;
  logic    rejected, rejected_next;
  status_t status_next;
  logic    done_next;
  step_t   step;
  logic    res_load;
  logic    a_load;

  assign res_load   = a_valid && (!result_valid || !result_stall);
  assign a_load     = !a_valid || res_load;
  assign char_stall = !a_load;

  tss_next u_next (
    .cur       (parse_state),
    .char_byte (a_char),
    .step      (step)
  );

  always_comb begin
    logic    rej_c;
    pstate_t st_c;
    rej_c = rejected || !step.ok;
    st_c  = (!rejected && step.ok) ? step.nxt : parse_state;
    if (a_empty) begin
      parse_state_next = StStart;
      rejected_next    = 1'b0;
      status_next      = STATUS_ACCEPTED;
      done_next        = 1'b1;
    end else if (a_last) begin
      parse_state_next = StStart;
      rejected_next    = 1'b0;
      status_next      = (!rej_c && st_c == StEnd) ? STATUS_ACCEPTED : STATUS_REJECTED;
      done_next        = 1'b1;
    end else begin
      parse_state_next = st_c;
      rejected_next    = rej_c;
      status_next      = rej_c ? STATUS_REJECTED : STATUS_PENDING;
      done_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
      parse_state  <= StStart;
      rejected     <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= char_valid;
      end
      if (res_load) begin
        result_valid <= 1'b1;
        parse_state  <= parse_state_next;
        rejected     <= rejected_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && char_valid) begin
      a_char  <= char_byte;
      a_last  <= last_char;
      a_empty <= empty_string;
    end
    if (res_load) begin
      status      <= status_next;
      string_done <= done_next;
    end
  end

endmodule

// File: rtl/tss_next.sv
// Character classifier and transition table of the shadow syntax automaton.
module tss_next (
  input  tss_pkg::pstate_t cur,
  input  logic [7:0]       char_byte,
  output tss_pkg::step_t   step
);
  import tss_pkg::*;

  char_class_t cls;

  always_comb begin
    if (char_byte >= "0" && char_byte <= "9") begin
      cls = CC_DIGIT;
    end else if ((char_byte >= "a" && char_byte <= "f") ||
                 (char_byte >= "A" && char_byte <= "F")) begin
      cls = CC_HEX;
    end else begin
      unique case (char_byte)
        "-":     cls = CC_MINUS;
        " ":     cls = CC_SPACE;
        "p":     cls = CC_P;
        "x":     cls = CC_X;
        "#":     cls = CC_HASH;
        ",":     cls = CC_COMMA;
        default: cls = CC_OTHER;
      endcase
    end
  end

  always_comb begin
    step.ok  = 1'b1;
    step.nxt = StStart;
    unique case (cls)
      CC_DIGIT: begin
        if (cur <= 5'd2) step.nxt = 5'd2;
        else if (cur >= 5'd5 && cur <= 5'd7) step.nxt = 5'd7;
        else if (cur >= 5'd19 && cur <= 5'd21) step.nxt = 5'd21;
        else if (cur >= 5'd11 && cur <= 5'd16) step.nxt = cur + 5'd1;
        else step.ok = 1'b0;
      end
      CC_HEX: begin
        if (cur >= 5'd11 && cur <= 5'd16) step.nxt = cur + 5'd1;
        else step.ok = 1'b0;
      end
      CC_MINUS: begin
        if (cur == 5'd0) step.nxt = 5'd1;
        else if (cur == 5'd5) step.nxt = 5'd6;
        else if (cur == 5'd19) step.nxt = 5'd20;
        else step.ok = 1'b0;
      end
      CC_SPACE: begin
        if (cur == 5'd0) step.nxt = 5'd0;
        else if (cur == 5'd4 || cur == 5'd5) step.nxt = 5'd5;
        else if (cur == 5'd9 || cur == 5'd10) step.nxt = 5'd10;
        else if (cur == 5'd18 || cur == 5'd19) step.nxt = 5'd19;
        else if (cur == 5'd15 || cur == 5'd16) step.nxt = cur;
        else step.ok = 1'b0;
      end
      CC_P: begin
        if (cur == 5'd2) step.nxt = 5'd3;
        else if (cur == 5'd7) step.nxt = 5'd8;
        else if (cur == 5'd21) step.nxt = 5'd22;
        else step.ok = 1'b0;
      end
      CC_X: begin
        if (cur == 5'd3) step.nxt = 5'd4;
        else if (cur == 5'd8) step.nxt = 5'd18;
        else if (cur == 5'd22) step.nxt = 5'd10;
        else step.ok = 1'b0;
      end
      CC_HASH: begin
        if (cur == 5'd10) step.nxt = 5'd11;
        else step.ok = 1'b0;
      end
      CC_COMMA: begin
        if (cur == StEnd) step.nxt = StStart;
        else step.ok = 1'b0;
      end
      default: step.ok = 1'b0;
    endcase
  end

endmodule

// File: rtl/tss_checker.sv
// Port-level assertions for the shadow syntax checker, with its bind.
module tss_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] status,
  input logic       string_done
);
  import tss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(status) && $stable(string_done))
    else $error("stalled result word changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == STATUS_PENDING || status == STATUS_ACCEPTED ||
                      status == STATUS_REJECTED))
    else $error("undefined status code");

  a_pend: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_PENDING |-> !string_done)
    else $error("pending status on closing word");

  a_rst: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word valid right after reset");

endmodule

bind text_shadow_syntax_checker tss_checker u_tss_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .string_done  (string_done)
);

// File: tb/shadow_verdict_check.sv
`timescale 1ns / 1ps
// Watches both word channels, predicts each status word and compares it with the block.
module shadow_verdict_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_stall,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  input  logic       empty_string,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [1:0] status,
  input  logic       string_done,
  output int         n_fail,
  output int         n_open,
  output int         n_checked,
  output int         n_accepted
);
  import tss_pkg::*;

  typedef struct packed {
    status_t status;
    logic    done;
  } verdict_t;

  verdict_t verdicts_due[$];
  pstate_t  shadow_state;
  logic     shadow_bad;

  initial begin
    n_fail       = 0;
    n_open       = 0;
    n_checked    = 0;
    n_accepted   = 0;
    shadow_state = StStart;
    shadow_bad   = 1'b0;
  end

  function automatic logic is_dec(logic [7:0] c);
    return (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_hex_alpha(logic [7:0] c);
    return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // one automaton step; ok low means no transition
  function automatic step_t shadow_next(pstate_t s, logic [7:0] c);
    step_t r;
    r.ok  = 1'b1;
    r.nxt = StStart;
    if (is_dec(c)) begin
      if (s <= 5'd2) r.nxt = 5'd2;
      else if (s >= 5'd5 && s <= 5'd7) r.nxt = 5'd7;
      else if (s >= 5'd19 && s <= 5'd21) r.nxt = 5'd21;
      else if (s >= 5'd11 && s <= 5'd16) r.nxt = s + 5'd1;
      else r.ok = 1'b0;
    end else if (is_hex_alpha(c)) begin
      if (s >= 5'd11 && s <= 5'd16) r.nxt = s + 5'd1;
      else r.ok = 1'b0;
    end else begin
      case (c)
        "-": begin
          if (s == 5'd0) r.nxt = 5'd1;
          else if (s == 5'd5) r.nxt = 5'd6;
          else if (s == 5'd19) r.nxt = 5'd20;
          else r.ok = 1'b0;
        end
        " ": begin
          if (s == 5'd0) r.nxt = 5'd0;
          else if (s == 5'd4 || s == 5'd5) r.nxt = 5'd5;
          else if (s == 5'd9 || s == 5'd10) r.nxt = 5'd10;
          else if (s == 5'd18 || s == 5'd19) r.nxt = 5'd19;
          else if (s == 5'd15 || s == 5'd16) r.nxt = s;
          else r.ok = 1'b0;
        end
        "p": begin
          if (s == 5'd2) r.nxt = 5'd3;
          else if (s == 5'd7) r.nxt = 5'd8;
          else if (s == 5'd21) r.nxt = 5'd22;
          else r.ok = 1'b0;
        end
        "x": begin
          if (s == 5'd3) r.nxt = 5'd4;
          else if (s == 5'd8) r.nxt = 5'd18;
          else if (s == 5'd22) r.nxt = 5'd10;
          else r.ok = 1'b0;
        end
        "#": begin
          if (s == 5'd10) r.nxt = 5'd11;
          else r.ok = 1'b0;
        end
        ",": begin
          if (s == StEnd) r.nxt = StStart;
          else r.ok = 1'b0;
        end
        default: r.ok = 1'b0;
      endcase
    end
    if (!r.ok) r.nxt = StStart;
    return r;
  endfunction

  task automatic predict_word(logic [7:0] c, logic fin, logic emp);
    verdict_t v;
    step_t    nx;
    if (emp) begin
      shadow_state = StStart;
      shadow_bad   = 1'b0;
      v.status     = STATUS_ACCEPTED;
      v.done       = 1'b1;
    end else begin
      if (!shadow_bad) begin
        nx = shadow_next(shadow_state, c);
        if (nx.ok) shadow_state = nx.nxt;
        else shadow_bad = 1'b1;
      end
      if (fin) begin
        if (!shadow_bad && shadow_state == StEnd) v.status = STATUS_ACCEPTED;
        else v.status = STATUS_REJECTED;
        v.done       = 1'b1;
        shadow_state = StStart;
        shadow_bad   = 1'b0;
      end else begin
        if (shadow_bad) v.status = STATUS_REJECTED;
        else v.status = STATUS_PENDING;
        v.done = 1'b0;
      end
    end
    verdicts_due.insert(verdicts_due.size(), v);
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (char_valid && !char_stall) predict_word(char_byte, last_char, empty_string);
      if (result_valid && !result_stall) begin
        n_checked++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected status word, expected none, got status %0d done %0b",
                   $time, status, string_done);
          n_fail++;
        end else begin
          v = verdicts_due.pop_front();
          if (v.status == STATUS_ACCEPTED && v.done) n_accepted++;
          if (status !== v.status) begin
            $display("%0t: status mismatch, expected %0d got %0d", $time, v.status, status);
            n_fail++;
          end
          if (string_done !== v.done) begin
            $display("%0t: string_done mismatch, expected %0b got %0b",
                     $time, v.done, string_done);
            n_fail++;
          end
        end
      end
    end
    n_open = verdicts_due.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, shadow-list character stimulus and the final verdict.
module tb;
  import tss_pkg::*;

  localparam int Limit      = 400000;
  localparam int RandWords  = 1750;
  localparam int QuietAfter = 1500;

  typedef logic [7:0] ch_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       char_valid   = 1'b0;
  logic       char_stall;
  ch_t        char_byte    = 8'h00;
  logic       last_char    = 1'b0;
  logic       empty_string = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] status;
  logic       string_done;

  int  n_fail;
  int  n_open;
  int  n_checked;
  int  n_accepted;
  ch_t line_q[$];
  bit  idle_on    = 1'b0;
  int  n_sent     = 0;
  int  n_strings  = 0;
  int  n_clean    = 0;
  int  cycles     = 0;
  int  stall_left = 0;

  text_shadow_syntax_checker dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_byte    (char_byte),
    .last_char    (last_char),
    .empty_string (empty_string),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .string_done  (string_done)
  );

  shadow_verdict_check u_check (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_byte    (char_byte),
    .last_char    (last_char),
    .empty_string (empty_string),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .string_done  (string_done),
    .n_fail       (n_fail),
    .n_open       (n_open),
    .n_checked    (n_checked),
    .n_accepted   (n_accepted)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, n_open);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!idle_on) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 15);
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_word(ch_t c, logic fin, logic emp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    char_valid   <= 1'b1;
    char_byte    <= c;
    last_char    <= fin;
    empty_string <= emp;
    do @(posedge clk); while (char_stall);
    n_sent++;
  endtask

  task automatic send_line(bit close);
    for (int i = 0; i < line_q.size(); i++)
      send_word(line_q[i], close && (i == line_q.size() - 1), 1'b0);
  endtask

  task automatic add_ch(ch_t c);
    line_q.insert(line_q.size(), c);
  endtask

  task automatic load_str(string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) add_ch(s[i]);
  endtask

  function automatic ch_t hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return ch_t'("0" + r);
    else if (r < 16) return ch_t'("a" + r - 10);
    else return ch_t'("A" + r - 16);
  endfunction

  // characters close to the syntax, or now and then any byte, for near-miss strings
  function automatic ch_t near_char();
    case ($urandom_range(0, 8))
      0: return " ";
      1: return "-";
      2: return "p";
      3: return "x";
      4: return "#";
      5: return ",";
      6: return ch_t'("0" + $urandom_range(0, 9));
      7: return hex_char();
      default: return ch_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_spaces(int lo, int hi);
    repeat ($urandom_range(lo, hi)) add_ch(" ");
  endtask

  task automatic add_len();
    if ($urandom_range(0, 2) == 0) add_ch("-");
    repeat ($urandom_range(1, 3)) add_ch(ch_t'("0" + $urandom_range(0, 9)));
    add_ch("p");
    add_ch("x");
  endtask

  task automatic build_shadow();
    int n;
    line_q.delete();
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    for (int e = 0; e < n; e++) begin
      if (e > 0) add_ch(",");
      add_spaces(0, 1);
      add_len();
      add_ch(" ");
      add_spaces(0, 1);
      add_len();
      add_ch(" ");
      add_spaces(0, 1);
      add_len();
      add_spaces(0, 2);
      add_ch("#");
      repeat (4) add_ch(hex_char());
      add_spaces(0, 2);
      add_ch(hex_char());
      add_spaces(0, 2);
      add_ch(hex_char());
    end
  endtask

  task automatic mangle();
    int pos;
    pos = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 2))
      0: line_q[pos] = near_char();
      1: line_q.delete(pos);
      default: line_q.insert(pos, near_char());
    endcase
    if (line_q.size() == 0) add_ch(near_char());
  endtask

  initial begin
    int kind;
    int keep;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty word wins, extremes, sticky reject, dropped string, spaced colour
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    load_str("x ");
    send_line(1'b1);
    send_word("-", 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    load_str("0px 0px 0px#afA0 9 F");
    send_line(1'b1);

    while (n_sent < RandWords) begin
      idle_on = (n_sent < QuietAfter) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      n_strings++;
      if (kind < 55) begin
        build_shadow();
        send_line(1'b1);
        n_clean++;
      end else if (kind < 80) begin
        build_shadow();
        mangle();
        send_line(1'b1);
      end else if (kind < 88) begin
        line_q.delete();
        repeat ($urandom_range(1, 8))
          add_ch($urandom_range(0, 1) ? ch_t'($urandom_range(0, 255)) : near_char());
        send_line(1'b1);
      end else if (kind < 94) begin
        send_word(ch_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        // cut short: closed early, or dropped by an empty word
        build_shadow();
        keep = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > keep) void'(line_q.pop_back());
        if ($urandom_range(0, 1)) begin
          send_line(1'b1);
        end else begin
          send_line(1'b0);
          send_word(ch_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
      end
    end
    char_valid <= 1'b0;
    idle_on = 1'b0;

    while (n_open != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d character words in %0d random strings (%0d well-formed), plus directed cases",
             n_sent, n_strings, n_clean);
    $display("%0d status words checked, %0d strings accepted, %0d words left over",
             n_checked, n_accepted, n_open);
    if (n_fail == 0 && n_open == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
